// ===== design/pddaw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID core package
// Shared widths, constants, codes and the arithmetic unit request types.
// ----------------------------------------------------------------------------
package pddaw_pkg;

    localparam int VAL_W  = 48;
    localparam int GAIN_W = 32;
    localparam int OPA_W  = 64;
    localparam int OPB_W  = 35;
    localparam int IDX_W  = 3;

    localparam logic [63:0] Q48_MAX = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic [IDX_W-1:0] CFG_GAIN_P     = 3'd0;
    localparam logic [IDX_W-1:0] CFG_GAIN_I     = 3'd1;
    localparam logic [IDX_W-1:0] CFG_GAIN_D     = 3'd2;
    localparam logic [IDX_W-1:0] CFG_FILTER_TAU = 3'd3;
    localparam logic [IDX_W-1:0] CFG_OUTPUT_MAX = 3'd4;
    localparam logic [IDX_W-1:0] CFG_OUTPUT_MIN = 3'd5;

    localparam logic [1:0] STAT_NORMAL    = 2'd0;
    localparam logic [1:0] STAT_SATURATED = 2'd1;
    localparam logic [1:0] STAT_REJECTED  = 2'd2;

    localparam logic OP_CLEAR_INTEGRAL = 1'b1;

    // Request to the shared multiply/divide unit: (a*b)>>sh or (a*b)/den,
    // truncated towards zero and magnitude limited.
    typedef struct packed {
        logic                    div_mode;
        logic                    sh17;
        logic                    lim_wide;
        logic signed [OPA_W-1:0] a;
        logic signed [OPB_W-1:0] b;
        logic [63:0]             den;
    } pd_req_t;

    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic signed [63:0]      result;
    } pd_resp_t;

endpackage
`default_nettype wire

// ===== design/pddaw_mdu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID core multiply/divide unit
// Shift-add multiplier, one operand bit a cycle, followed either by a
// scaling shift or by a restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pddaw_mdu (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  start,
    input  pddaw_pkg::pd_req_t   req,
    output pddaw_pkg::pd_resp_t  resp
);
    import pddaw_pkg::*;

    localparam int PROD_W = OPA_W + OPB_W;

    typedef enum logic [5:0] {
        U_IDLE = 6'b000001,
        U_MUL  = 6'b000010,
        U_SHF  = 6'b000100,
        U_DCHK = 6'b001000,
        U_DIV  = 6'b010000,
        U_DEND = 6'b100000
    } u_state_t;

    u_state_t            state_reg;
    logic [6:0]          cnt_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [OPA_W-1:0]    amag_reg;
    logic                neg_reg;
    logic                div_reg;
    logic                sh17_reg;
    logic [63:0]         lim_reg;
    logic [63:0]         den_reg;
    logic [63:0]         rem_reg;
    logic [63:0]         lo_reg;
    logic signed [63:0]  res_reg;
    logic                done_reg;

    logic [OPA_W:0]      mul_sum;
    logic [PROD_W-1:0]   shifted;
    logic [63:0]         q_shf;
    logic [64:0]         rsh;
    logic                ge;
    logic [64:0]         diff;
    logic [63:0]         q_div;

    always_comb begin
        mul_sum = {1'b0, prod_reg[PROD_W-1:OPB_W]}
                + (prod_reg[0] ? {1'b0, amag_reg} : '0);
        shifted = sh17_reg ? (prod_reg >> 17) : (prod_reg >> 16);
        if ((|shifted[PROD_W-1:64]) || (shifted[63:0] > lim_reg)) begin
            q_shf = lim_reg;
        end else begin
            q_shf = shifted[63:0];
        end
        rsh   = {rem_reg, lo_reg[63]};
        ge    = rsh >= {1'b0, den_reg};
        diff  = rsh - {1'b0, den_reg};
        q_div = (lo_reg > lim_reg) ? lim_reg : lo_reg;
    end

    always_ff @(posedge aclk) begin
        done_reg <= 1'b0;
        if (!aresetn) begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                U_IDLE: begin
                    if (start) begin
                        amag_reg  <= req.a[OPA_W-1] ? (~req.a + 1'b1) : req.a;
                        prod_reg  <= {{OPA_W{1'b0}},
                                      (req.b[OPB_W-1] ? (~req.b + 1'b1) : req.b)};
                        neg_reg   <= req.a[OPA_W-1] ^ req.b[OPB_W-1];
                        div_reg   <= req.div_mode;
                        sh17_reg  <= req.sh17;
                        lim_reg   <= req.lim_wide ? I64_MAX : Q48_MAX;
                        den_reg   <= req.den;
                        cnt_reg   <= '0;
                        state_reg <= U_MUL;
                    end
                end
                U_MUL: begin
                    prod_reg <= {mul_sum, prod_reg[OPB_W-1:1]};
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == 7'(OPB_W - 1)) begin
                        state_reg <= div_reg ? U_DCHK : U_SHF;
                    end
                end
                U_SHF: begin
                    res_reg   <= neg_reg ? $signed(~q_shf + 1'b1) : $signed(q_shf);
                    done_reg  <= 1'b1;
                    state_reg <= U_IDLE;
                end
                U_DCHK: begin
                    // A zero divisor or a quotient that cannot fit 64 bits goes straight to the limit.
                    if ((den_reg == '0) ||
                        ({{(128-PROD_W){1'b0}}, prod_reg[PROD_W-1:64]} >= den_reg)) begin
                        res_reg   <= neg_reg ? $signed(~lim_reg + 1'b1) : $signed(lim_reg);
                        done_reg  <= 1'b1;
                        state_reg <= U_IDLE;
                    end else begin
                        rem_reg   <= {{(128-PROD_W){1'b0}}, prod_reg[PROD_W-1:64]};
                        lo_reg    <= prod_reg[63:0];
                        cnt_reg   <= '0;
                        state_reg <= U_DIV;
                    end
                end
                U_DIV: begin
                    rem_reg <= ge ? diff[63:0] : rsh[63:0];
                    lo_reg  <= {lo_reg[62:0], ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 7'd63) begin
                        state_reg <= U_DEND;
                    end
                end
                U_DEND: begin
                    res_reg   <= neg_reg ? $signed(~q_div + 1'b1) : $signed(q_div);
                    done_reg  <= 1'b1;
                    state_reg <= U_IDLE;
                end
                default: state_reg <= U_IDLE;
            endcase
        end
    end

    assign resp.busy   = (state_reg != U_IDLE);
    assign resp.done   = done_reg;
    assign resp.result = res_reg;

endmodule
`default_nettype wire

// ===== design/pid_dirty_derivative_antiwindup_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID controller core with filtered derivative and anti-windup
// Control steps over one shared multiply/divide unit under a sequencer.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the s_ stream; one result per item leaves on the m_ stream.
// Gains, filter time constant and output clamp are written through the
// cfg_ port; the user must write them only while the block is idle, as the
// block itself does not enforce this. A write takes effect at once. Each
// multiplication and division runs on the shared unit, which handles one
// operand bit per cycle. A step with the filtered derivative adds two
// divisions to one with a supplied rate, and an anti-windup correction a
// third. A clear or rejected item skips the unit and goes straight to the
// output stage. s_tready is high only while the sequencer waits for an item;
// the next item is taken while a result still waits in the output register.
// If the receiver stalls, a finished step holds until that register frees.
// Reset clears the controller state, the gains and the clamp to their
// defaults and empties the output register.
// ----------------------------------------------------------------------------
module pid_dirty_derivative_antiwindup_core (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // setpoint[47:0], measured[95:48], time_step[127:96], measured_rate[175:128]
    input  wire  [175:0]                    s_tdata,
    // opcode[0], rate_valid[1]
    input  wire  [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // control[47:0]
    output logic [47:0]                     m_tdata,
    // status[1:0]
    output logic [1:0]                      m_tuser,
    input  wire                             cfg_wr_en,
    input  wire  [pddaw_pkg::IDX_W-1:0]     cfg_index,
    input  wire  [47:0]                     cfg_wdata
);
    import pddaw_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_PT    = 10'b0000000010,
        S_T1    = 10'b0000000100,
        S_T2    = 10'b0000001000,
        S_DT    = 10'b0000010000,
        S_INC   = 10'b0000100000,
        S_IT    = 10'b0001000000,
        S_CLAMP = 10'b0010000000,
        S_AW    = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } state_t;

    localparam logic signed [48:0] ERR_LIMIT = 49'sd655359934464;
    localparam logic signed [48:0] SAT48     = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [64:0] SAT64     = 65'sh0_7FFF_FFFF_FFFF_FFFF;

    state_t                state_reg;
    logic                  issued_reg;

    logic signed [31:0]    gain_p_reg, gain_i_reg, gain_d_reg;
    logic [31:0]           tau_reg;
    logic signed [47:0]    omax_reg, omin_reg;

    logic signed [63:0]    integ_reg;
    logic signed [47:0]    fr_reg, perr_reg, pmeas_reg;

    logic signed [47:0]    meas_reg, rate_reg;
    logic signed [48:0]    err_reg;
    logic [16:0]           dt_reg;
    logic                  rok_reg;
    logic signed [47:0]    p_reg, d_reg, it_reg, t1_reg;
    logic signed [49:0]    room_reg;
    logic [47:0]           res_ctrl_reg;
    logic [1:0]            res_stat_reg;

    pd_req_t               mdu_req;
    pd_resp_t              mdu_resp;
    logic                  op_state;
    logic                  mdu_start;

    logic signed [48:0]    err_w;
    logic [31:0]           in_dt;
    logic [33:0]           den_f;
    logic signed [48:0]    fr_sum;
    logic signed [64:0]    integ_sum;
    logic signed [49:0]    u_w, us_w, room_w, omax_w, omin_w, it_abs, room_abs;
    logic                  sat_w;
    state_t                after_d;

    assign s_tready  = (state_reg == S_IDLE);
    assign op_state  = (state_reg == S_PT) || (state_reg == S_T1) || (state_reg == S_T2) ||
                       (state_reg == S_DT) || (state_reg == S_INC) || (state_reg == S_IT) ||
                       (state_reg == S_AW);
    assign mdu_start = op_state && !issued_reg;

    pddaw_mdu u_mdu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mdu_start),
        .req     (mdu_req),
        .resp    (mdu_resp)
    );

    always_comb begin
        err_w  = $signed({s_tdata[47], s_tdata[47:0]}) - $signed({s_tdata[95], s_tdata[95:48]});
        in_dt  = s_tdata[127:96];
        den_f  = {1'b0, tau_reg, 1'b0} + {17'b0, dt_reg};
        fr_sum = $signed({t1_reg[47], t1_reg}) +
                 $signed({mdu_resp.result[47], mdu_resp.result[47:0]});
        integ_sum = $signed({integ_reg[63], integ_reg}) +
                    $signed({mdu_resp.result[63], mdu_resp.result});
        after_d = (gain_i_reg > 0) ? S_INC : S_CLAMP;

        omax_w = {{2{omax_reg[47]}}, omax_reg};
        omin_w = {{2{omin_reg[47]}}, omin_reg};
        u_w    = $signed({{2{p_reg[47]}}, p_reg}) + $signed({{2{it_reg[47]}}, it_reg})
               - $signed({{2{d_reg[47]}}, d_reg});
        // With an inverted clamp the upper bound is taken when exceeded, else the lower bound.
        if (u_w > omax_w) begin
            us_w = omax_w;
        end else if (u_w < omin_w) begin
            us_w = omin_w;
        end else begin
            us_w = u_w;
        end
        sat_w    = (u_w != us_w);
        room_w   = us_w - $signed({{2{p_reg[47]}}, p_reg}) + $signed({{2{d_reg[47]}}, d_reg});
        it_abs   = it_reg[47] ? -$signed({{2{it_reg[47]}}, it_reg})
                              : $signed({{2{it_reg[47]}}, it_reg});
        room_abs = room_w[49] ? -room_w : room_w;

        mdu_req          = '0;
        mdu_req.lim_wide = 1'b0;
        case (state_reg)
            S_PT: begin
                mdu_req.a = {{15{err_reg[48]}}, err_reg};
                mdu_req.b = {{3{gain_p_reg[31]}}, gain_p_reg};
            end
            S_T1: begin
                mdu_req.div_mode = 1'b1;
                mdu_req.a   = {{16{fr_reg[47]}}, fr_reg};
                mdu_req.b   = $signed({2'b0, tau_reg, 1'b0}) - $signed({18'b0, dt_reg});
                mdu_req.den = {30'b0, den_f};
            end
            S_T2: begin
                mdu_req.div_mode = 1'b1;
                mdu_req.a   = 64'($signed({meas_reg[47], meas_reg}) -
                                  $signed({pmeas_reg[47], pmeas_reg}));
                mdu_req.b   = 35'sd131072;
                mdu_req.den = {30'b0, den_f};
            end
            S_DT: begin
                mdu_req.a = rok_reg ? {{16{rate_reg[47]}}, rate_reg}
                                    : {{16{fr_reg[47]}}, fr_reg};
                mdu_req.b = {{3{gain_d_reg[31]}}, gain_d_reg};
            end
            S_INC: begin
                mdu_req.sh17     = 1'b1;
                mdu_req.lim_wide = 1'b1;
                mdu_req.a = 64'($signed({err_reg[47], err_reg[47:0]}) +
                                $signed({perr_reg[47], perr_reg}));
                mdu_req.b = {18'b0, dt_reg};
            end
            S_IT: begin
                mdu_req.a = integ_reg;
                mdu_req.b = {{3{gain_i_reg[31]}}, gain_i_reg};
            end
            S_AW: begin
                mdu_req.div_mode = 1'b1;
                mdu_req.lim_wide = 1'b1;
                mdu_req.a   = {{14{room_reg[49]}}, room_reg};
                mdu_req.b   = 35'sd65536;
                mdu_req.den = {32'b0, gain_i_reg};
            end
            default: mdu_req.a = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            tau_reg    <= '0;
            omax_reg   <= Q48_MAX[47:0];
            omin_reg   <= 48'sh8000_0000_0000;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_GAIN_P:     gain_p_reg <= cfg_wdata[31:0];
                CFG_GAIN_I:     gain_i_reg <= cfg_wdata[31:0];
                CFG_GAIN_D:     gain_d_reg <= cfg_wdata[31:0];
                CFG_FILTER_TAU: tau_reg    <= cfg_wdata[31:0];
                CFG_OUTPUT_MAX: omax_reg   <= cfg_wdata;
                CFG_OUTPUT_MIN: omin_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            issued_reg <= 1'b0;
            m_tvalid   <= 1'b0;
            integ_reg  <= '0;
            fr_reg     <= '0;
            perr_reg   <= '0;
            pmeas_reg  <= '0;
        end else begin
            if (m_tvalid && m_tready && state_reg != S_FIN) begin
                m_tvalid <= 1'b0;
            end
            if (mdu_resp.done) begin
                issued_reg <= 1'b0;
            end else if (mdu_start) begin
                issued_reg <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        meas_reg     <= s_tdata[95:48];
                        rate_reg     <= s_tdata[175:128];
                        rok_reg      <= s_tuser[1];
                        err_reg      <= err_w;
                        p_reg        <= '0;
                        d_reg        <= '0;
                        it_reg       <= '0;
                        res_ctrl_reg <= '0;
                        if (s_tuser[0] == OP_CLEAR_INTEGRAL) begin
                            integ_reg    <= '0;
                            res_stat_reg <= STAT_NORMAL;
                            state_reg    <= S_FIN;
                        end else if ((in_dt == '0) || (err_w > ERR_LIMIT) ||
                                     (err_w < -ERR_LIMIT)) begin
                            res_stat_reg <= STAT_REJECTED;
                            state_reg    <= S_FIN;
                        end else begin
                            // A step longer than one second counts as no time.
                            if (in_dt > 32'd65536) begin
                                dt_reg <= '0;
                                fr_reg <= '0;
                            end else begin
                                dt_reg <= in_dt[16:0];
                            end
                            state_reg <= S_PT;
                        end
                    end
                end
                S_PT: begin
                    if (mdu_resp.done) begin
                        p_reg <= mdu_resp.result[47:0];
                        if (gain_d_reg > 0 && rok_reg) begin
                            state_reg <= S_DT;
                        end else if (gain_d_reg > 0 && dt_reg != '0) begin
                            state_reg <= S_T1;
                        end else begin
                            state_reg <= after_d;
                        end
                    end
                end
                S_T1: begin
                    if (mdu_resp.done) begin
                        t1_reg    <= mdu_resp.result[47:0];
                        state_reg <= S_T2;
                    end
                end
                S_T2: begin
                    if (mdu_resp.done) begin
                        if (fr_sum > SAT48) begin
                            fr_reg <= SAT48[47:0];
                        end else if (fr_sum < -SAT48) begin
                            fr_reg <= 48'(-SAT48);
                        end else begin
                            fr_reg <= fr_sum[47:0];
                        end
                        state_reg <= S_DT;
                    end
                end
                S_DT: begin
                    if (mdu_resp.done) begin
                        d_reg     <= mdu_resp.result[47:0];
                        state_reg <= after_d;
                    end
                end
                S_INC: begin
                    if (mdu_resp.done) begin
                        if (integ_sum > SAT64) begin
                            integ_reg <= SAT64[63:0];
                        end else if (integ_sum < -SAT64) begin
                            integ_reg <= 64'(-SAT64);
                        end else begin
                            integ_reg <= integ_sum[63:0];
                        end
                        state_reg <= S_IT;
                    end
                end
                S_IT: begin
                    if (mdu_resp.done) begin
                        it_reg    <= mdu_resp.result[47:0];
                        state_reg <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    perr_reg     <= err_reg[47:0];
                    pmeas_reg    <= meas_reg;
                    res_ctrl_reg <= us_w[47:0];
                    res_stat_reg <= sat_w ? STAT_SATURATED : STAT_NORMAL;
                    room_reg     <= room_w;
                    // Back-compute the integrator so that I just fills the room left.
                    if (sat_w && (it_abs > room_abs)) begin
                        state_reg <= S_AW;
                    end else begin
                        state_reg <= S_FIN;
                    end
                end
                S_AW: begin
                    if (mdu_resp.done) begin
                        integ_reg <= mdu_resp.result;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!m_tvalid || m_tready) begin
                        m_tvalid  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_FIN && (!m_tvalid || m_tready)) begin
            m_tdata <= res_ctrl_reg;
            m_tuser <= res_stat_reg;
        end
    end

`ifndef SYNTH
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mdu_start |-> !mdu_resp.busy)
        else $error("arithmetic unit started while busy");

    a_ready_unit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !mdu_resp.busy)
        else $error("input ready while arithmetic unit busy");

    a_done_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        mdu_resp.done |-> (issued_reg && op_state))
        else $error("arithmetic result with no request outstanding");

    a_fin_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && (!m_tvalid || m_tready)) |=> (m_tvalid && s_tready))
        else $error("finished step not presented");
`endif

endmodule
`default_nettype wire

// ===== test/pid_dirty_derivative_antiwindup_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID core testbench
// Drives control steps, integrator clears and register writes into the core
// and checks every result against a bit-exact fixed-point controller model
// kept in the bench, under several patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module pid_dirty_derivative_antiwindup_core_tb;
    import pddaw_pkg::*;

    localparam longint LIM48 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint LIM64 = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ONE_SEC = 65536;
    localparam longint ERR_MAX = 64'sd9999999 * 65536;
    localparam longint CYCLE_LIMIT = 4000000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [175:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_wr_en;
    logic [IDX_W-1:0] cfg_index;
    logic [47:0]  cfg_wdata;

    typedef struct {
        logic [47:0] control;
        logic [1:0]  status;
    } ctl_result_t;

    ctl_result_t pending_results[$];

    // Controller model state and registers.
    longint kp, ki, kd, tau, out_hi, out_lo;
    longint integ, frate, prev_err, prev_meas;

    int  send_idle_pct, recv_stall_pct;
    int  mismatches;
    longint cycles;

    pid_dirty_derivative_antiwindup_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    function automatic longint magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    // (a*b)>>sh truncated towards zero, magnitude limited.
    function automatic longint scaled_product(longint a, longint b, int sh, longint lim);
        logic [127:0] p;
        logic [127:0] q;
        bit neg;
        neg = (a < 0) != (b < 0);
        p = 128'(magnitude(a)) * 128'(magnitude(b));
        q = p >> sh;
        if (q > 128'(lim)) q = 128'(lim);
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    // (a*b)/den truncated towards zero, magnitude limited.
    function automatic longint scaled_quotient(longint a, longint b, logic [63:0] den,
                                               longint lim);
        logic [127:0] p;
        logic [127:0] q;
        bit neg;
        neg = (a < 0) != (b < 0);
        p = 128'(magnitude(a)) * 128'(magnitude(b));
        if (den == 0) q = 128'(lim);
        else q = p / 128'(den);
        if (q > 128'(lim)) q = 128'(lim);
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint clip48(longint v);
        return v > LIM48 ? LIM48 : (v < -LIM48 ? -LIM48 : v);
    endfunction

    function automatic longint integ_add(longint a, longint b);
        if (b > 0 && a > LIM64 - b) return LIM64;
        if (b < 0 && a < -LIM64 - b) return -LIM64;
        return a + b;
    endfunction

    function automatic longint sx48(logic [47:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic void model_write(logic [IDX_W-1:0] idx, logic [47:0] val);
        case (idx)
            CFG_GAIN_P:     kp = longint'(signed'(val[31:0]));
            CFG_GAIN_I:     ki = longint'(signed'(val[31:0]));
            CFG_GAIN_D:     kd = longint'(signed'(val[31:0]));
            CFG_FILTER_TAU: tau = longint'(val[31:0]);
            CFG_OUTPUT_MAX: out_hi = sx48(val);
            CFG_OUTPUT_MIN: out_lo = sx48(val);
            default: ;
        endcase
    endfunction

    function automatic ctl_result_t control_step(logic op, logic [47:0] sp_r,
                                                 logic [47:0] meas_r, logic [31:0] dt_r,
                                                 logic [47:0] rate_r, logic rate_ok);
        ctl_result_t r;
        longint sp, meas, dt, rate, err, p, it, d, u, us, room, t1, t2;
        logic [63:0] den;
        sp = sx48(sp_r);
        meas = sx48(meas_r);
        dt = longint'(dt_r);
        rate = sx48(rate_r);
        it = 0;
        d = 0;
        r.control = '0;
        r.status = STAT_NORMAL;
        if (op == OP_CLEAR_INTEGRAL) begin
            integ = 0;
            return r;
        end
        err = sp - meas;
        if (dt == 0 || err > ERR_MAX || err < -ERR_MAX) begin
            r.status = STAT_REJECTED;
            return r;
        end
        if (dt > ONE_SEC) begin
            dt = 0;
            frate = 0;
        end
        p = scaled_product(err, kp, 16, LIM48);
        if (kd > 0) begin
            if (rate_ok) begin
                d = scaled_product(rate, kd, 16, LIM48);
            end else if (dt > 0) begin
                den = 64'(2 * tau + dt);
                t1 = scaled_quotient(2 * tau - dt, frate, den, LIM48);
                t2 = scaled_quotient(meas - prev_meas, 2 * ONE_SEC, den, LIM48);
                frate = clip48(t1 + t2);
                d = scaled_product(frate, kd, 16, LIM48);
            end
        end
        if (ki > 0) begin
            integ = integ_add(integ, scaled_product(err + prev_err, dt, 17, LIM64));
            it = scaled_product(integ, ki, 16, LIM48);
        end
        prev_err = err;
        prev_meas = meas;
        u = p + it - d;
        us = u;
        if (u > out_hi) us = out_hi;
        else if (u < out_lo) us = out_lo;
        room = us - p + d;
        if (u != us && magnitude(it) > magnitude(room))
            integ = scaled_quotient(room, ONE_SEC, 64'(ki), LIM64);
        r.control = us[47:0];
        r.status = (u != us) ? STAT_SATURATED : STAT_NORMAL;
        return r;
    endfunction

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [47:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        model_write(idx, val);
    endtask

    // Waits for every result, then lets a worst-case step drain.
    task automatic settle();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    task automatic send_item(logic op, logic [47:0] sp, logic [47:0] meas,
                             logic [31:0] dt, logic [47:0] rate, logic rate_ok);
        @(posedge aclk);
        while ($urandom_range(99, 0) < send_idle_pct) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {rate, dt, meas, sp};
        s_tuser <= {rate_ok, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(control_step(op, sp, meas, dt, rate, rate_ok));
        s_tvalid <= 1'b0;
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    // Mostly moderate values so that steps get past the rejection check.
    task automatic random_step();
        logic [47:0] sp, meas;
        logic [31:0] dt;
        int kind;
        kind = $urandom_range(19, 0);
        sp = 48'(longint'($urandom_range(2000000, 0)) * 1024 - 1024000000);
        meas = sp - 48'(longint'($urandom_range(200000, 0)) * 256 - 25600000);
        dt = $urandom_range(65536, 1);
        if (kind == 0) dt = $urandom();
        else if (kind == 1) dt = 0;
        else if (kind == 2) begin
            sp = rand48();
            meas = rand48();
        end
        send_item(kind == 3, sp, meas, dt, rand48() >> $urandom_range(47, 0),
                  1'($urandom_range(1, 0)));
    endtask

    task automatic random_config();
        write_reg(CFG_GAIN_P, 48'($urandom()) >> $urandom_range(31, 8));
        write_reg(CFG_GAIN_I, {16'd0, $urandom()} >> $urandom_range(31, 0));
        write_reg(CFG_GAIN_D, {16'd0, $urandom()} >> $urandom_range(31, 0));
        write_reg(CFG_FILTER_TAU, {16'd0, $urandom()} >> $urandom_range(31, 12));
        write_reg(CFG_OUTPUT_MAX, 48'(longint'($urandom_range(40000, 0)) * 65536));
        write_reg(CFG_OUTPUT_MIN, 48'(-longint'($urandom_range(40000, 0)) * 65536));
    endtask

    task automatic test_directed();
        write_reg(CFG_GAIN_P, 48'h0000_0001_0000);
        write_reg(CFG_GAIN_I, 48'h0000_0000_8000);
        write_reg(CFG_GAIN_D, 48'h0000_0000_4000);
        write_reg(CFG_FILTER_TAU, 48'h0000_0000_1000);
        send_item(1'b0, 48'h0000_0010_0000, 48'h0, 32'h0000_1000, 48'h0, 1'b0);
        send_item(1'b0, 48'h0000_0010_0000, 48'h0000_0004_0000, 32'h0000_1000, 48'h0, 1'b0);
        send_item(1'b0, 48'h0000_0010_0000, 48'h0000_0008_0000, 32'h0001_0000,
                  48'hFFFF_FFF0_0000, 1'b1);
        // Rejections: zero time step and two errors beyond the limit, then an error right at the limit.
        send_item(1'b0, 48'h0000_0010_0000, 48'h0, 32'h0, 48'h0, 1'b0);
        send_item(1'b0, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 32'h1000, 48'h0, 1'b0);
        send_item(1'b0, 48'h0098_9680_0000, 48'h0, 32'h1000, 48'h0, 1'b0);
        send_item(1'b0, 48'h0098_967F_0000, 48'h0, 32'h1000, 48'h7FFF_FFFF_FFFF, 1'b1);
        // Long steps: filter cleared, with and without a supplied rate.
        send_item(1'b0, 48'h0000_0005_0000, 48'h0000_0001_0000, 32'h0001_0001, 48'h0, 1'b0);
        send_item(1'b0, 48'h0000_0005_0000, 48'h0, 32'hFFFF_FFFF, 48'h8000_0000_0000, 1'b1);
        send_item(OP_CLEAR_INTEGRAL, 48'hFFFF_FFFF_FFFF, 48'h0, 32'hFFFF_FFFF, 48'h0, 1'b1);
        settle();
        // Tight clamp forces saturation and integrator back-computation.
        write_reg(CFG_OUTPUT_MAX, 48'h0000_0002_0000);
        write_reg(CFG_OUTPUT_MIN, 48'hFFFF_FFFE_0000);
        send_item(1'b0, 48'h0000_0100_0000, 48'h0, 32'h0001_0000, 48'h0, 1'b0);
        send_item(1'b0, 48'h0000_0100_0000, 48'h0, 32'h0001_0000, 48'h0, 1'b0);
        send_item(1'b0, 48'hFFFF_FF00_0000, 48'h0, 32'h0001_0000, 48'h0, 1'b0);
        settle();
        // Inverted clamp, then extreme gains.
        write_reg(CFG_OUTPUT_MAX, 48'h8000_0000_0000);
        write_reg(CFG_OUTPUT_MIN, 48'h7FFF_FFFF_FFFF);
        send_item(1'b0, 48'h0000_0001_0000, 48'h0, 32'h0000_8000, 48'h0, 1'b0);
        send_item(1'b0, 48'hFFFF_FFFF_0000, 48'h0, 32'h0000_8000, 48'h0, 1'b0);
        settle();
        write_reg(CFG_GAIN_P, 48'h0000_7FFF_FFFF);
        write_reg(CFG_GAIN_I, 48'h0000_7FFF_FFFF);
        write_reg(CFG_GAIN_D, 48'h0000_7FFF_FFFF);
        write_reg(CFG_FILTER_TAU, 48'h0000_FFFF_FFFF);
        write_reg(CFG_OUTPUT_MAX, 48'h7FFF_FFFF_FFFF);
        write_reg(CFG_OUTPUT_MIN, 48'h8000_0000_0000);
        send_item(1'b0, 48'h0098_9680_0000, 48'h0, 32'h0001_0000, 48'h0, 1'b0);
        send_item(1'b0, 48'hFF67_6980_0000, 48'h0, 32'h0000_0001, 48'h0, 1'b0);
        settle();
        write_reg(CFG_GAIN_P, 48'h0000_8000_0000);
        write_reg(CFG_GAIN_I, 48'h0000_8000_0000);
        write_reg(CFG_GAIN_D, 48'h0000_8000_0000);
        write_reg(CFG_FILTER_TAU, 48'h0);
        send_item(1'b0, 48'h0000_0003_0000, 48'h0, 32'h0000_4000, 48'h0, 1'b0);
        send_item(1'b0, 48'h0000_0003_0000, 48'h0, 32'h0000_4000, 48'h1, 1'b1);
        settle();
    endtask

    task automatic test_random_phase(int send_pct, int recv_pct, int n);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        random_config();
        for (int i = 0; i < n; i++) random_step();
        // Hold off until the core has drained once mid-phase.
        while (pending_results.size() != 0) @(posedge aclk);
        for (int i = 0; i < n / 4; i++) random_step();
        settle();
    endtask

    // Result checker.
    always @(posedge aclk) begin
        ctl_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: control %h status %0d",
                             m_tdata, m_tuser);
            end else begin
                want = pending_results.pop_front();
                if (want.control !== m_tdata || want.status !== m_tuser) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected control %h status %0d, got %h %0d",
                                 want.control, want.status, m_tdata, m_tuser);
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("pid_dirty_derivative_antiwindup_core verification failed");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        cycles = 0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        kp = 0; ki = 0; kd = 0; tau = 0;
        out_hi = LIM48; out_lo = -LIM48 - 1;
        integ = 0; frate = 0; prev_err = 0; prev_meas = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_phase(0, 0, 130);
        test_random_phase(78, 0, 130);
        test_random_phase(0, 78, 130);
        test_random_phase(31, 31, 130);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("pid_dirty_derivative_antiwindup_core verification clean");
        end else begin
            $display("pid_dirty_derivative_antiwindup_core verification failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
design/pddaw_pkg.sv
design/pddaw_mdu.sv
design/pid_dirty_derivative_antiwindup_core.sv
test/pid_dirty_derivative_antiwindup_core_tb.sv
